[hdl/voxel_ray_traversal_defines.svh]
// ---------------------------------------------------------------------------
// voxel_ray_traversal_defines.svh
// Assertion macros for the checker file vrt_checker.sv.
// ---------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define VRT_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/vrt_pkg.sv]
// ---------------------------------------------------------------------------
// vrt_pkg
// Shared types and codes of the voxel ray traversal engine.
// ---------------------------------------------------------------------------
package vrt_pkg;

    typedef logic [31:0] vrt_time_t;

    // per-lane control from the sequencer
    typedef struct packed {
        logic load;   // latch ray, start both divisions
        logic mul;    // register te * dir
        logic upd;    // commit voxel, advance crossing on tie
    } vrt_lane_ctl_t;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_ANSWER = 1'b1;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;
    localparam logic [1:0] KIND_NORAY = 2'd3;

    // APB register map
    localparam logic [2:0] ADDR_MAX_DIST = 3'd0;

    localparam vrt_time_t TIME_SAT = 32'hFFFF_FFFF;

endpackage

[hdl/voxel_ray_traversal.sv]
// ---------------------------------------------------------------------------
// voxel_ray_traversal
// Fixed-point 3D grid walk: three axis lanes, a min merge and a sequencer.
// ---------------------------------------------------------------------------
//  channel  | dir | contents
//  s_axis   | in  | tuser: func; tdata: origin xyz, dir xyz, is_solid
//  m_axis   | out | tuser: kind; tdata: voxel xyz
//  apb      | in  | max_distance at byte address 0
//
//  Start transaction: the two divisions of each lane run, the quotients are
//  captured as the dividers go idle, then min, multiply and commit follow.
//  Answer transaction: min, multiply, commit; an answer with no ray in
//  flight or a hit goes straight to commit.
//  One transaction at a time; s_tready is high only while idle. A finished
//  result sits in the output register and the next input may be taken
//  while it waits; the commit of a further result holds until it drains.
//  rst_n is asynchronous; it clears the ray state and max_distance to
//  524288.
// ---------------------------------------------------------------------------
module voxel_ray_traversal
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int EPS_LSB   = 7
)
(
    input  logic         clk,
    input  logic         rst_n,
    // s_axis
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y,
                                    // dir_z, is_solid, pad
    input  logic         s_tuser,   // func
    // m_axis
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // voxel_x, voxel_y, voxel_z
    output logic [1:0]   m_tuser,   // kind
    // apb
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MIN  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [1:0] MODE_WALK  = 2'd0;
    localparam logic [1:0] MODE_HIT   = 2'd1;
    localparam logic [1:0] MODE_NORAY = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic        walking_reg, walking_next;
    logic [30:0] maxd_reg;
    vrt_time_t   tmin_reg, tmin_next;
    logic        ovld_reg, ovld_next;
    logic [1:0]  okind_reg, okind_next;
    logic [47:0] odata_reg, odata_next;

    vrt_lane_ctl_t ctl;
    logic          in_acc, out_free, miss;
    logic [2:0]    lane_busy;
    vrt_time_t     lane_cross [3];
    logic [15:0]   vnew [3];
    logic [15:0]   vcur [3];
    vrt_time_t     tmin_c;
    logic signed [31:0] org [3];
    logic signed [17:0] dirv [3];

    // payload unpack
    assign org[0]  = s_tdata[31:0];
    assign org[1]  = s_tdata[63:32];
    assign org[2]  = s_tdata[95:64];
    assign dirv[0] = s_tdata[113:96];
    assign dirv[1] = s_tdata[131:114];
    assign dirv[2] = s_tdata[149:132];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !ovld_reg || m_tready;
    assign miss     = tmin_reg > {1'b0, maxd_reg};

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_DIST) ? {1'b0, maxd_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            maxd_reg <= 31'd524288;
        else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_DIST)
            maxd_reg <= pwdata[30:0];
    end

    // axis lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vrt_lane #(.FRAC_BITS(FRAC_BITS), .EPS_LSB(EPS_LSB)) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .origin    (org[i]),
            .dir       (dirv[i]),
            .tmin      (tmin_reg),
            .busy      (lane_busy[i]),
            .crossing  (lane_cross[i]),
            .voxel_new (vnew[i]),
            .voxel_cur (vcur[i])
        );
    end

    vrt_merge u_merge (
        .cross_x (lane_cross[0]),
        .cross_y (lane_cross[1]),
        .cross_z (lane_cross[2]),
        .tmin    (tmin_c)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        walking_next = walking_reg;
        tmin_next    = tmin_reg;
        ovld_next    = ovld_reg && !m_tready;
        okind_next   = okind_reg;
        odata_next   = odata_reg;
        ctl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == FUNC_START)
                    begin
                        ctl.load     = 1'b1;
                        walking_next = 1'b1;
                        mode_next    = MODE_WALK;
                        state_next   = ST_DIV;
                    end
                    else if (!walking_reg)
                    begin
                        mode_next  = MODE_NORAY;
                        state_next = ST_FIN;
                    end
                    else if (s_tdata[150])
                    begin
                        walking_next = 1'b0;
                        mode_next    = MODE_HIT;
                        state_next   = ST_FIN;
                    end
                    else
                    begin
                        mode_next  = MODE_WALK;
                        state_next = ST_MIN;
                    end
                end
            end
            ST_DIV:
            begin
                if (lane_busy == '0)
                    state_next = ST_MIN;
            end
            ST_MIN:
            begin
                tmin_next  = tmin_c;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    state_next = ST_IDLE;
                    case (mode_reg)
                        MODE_WALK:
                        begin
                            ctl.upd = 1'b1;
                            if (miss)
                            begin
                                walking_next = 1'b0;
                                okind_next   = KIND_MISS;
                                odata_next   = {16'h0000, 16'hFFFF, 16'h0000};
                            end
                            else
                            begin
                                okind_next = KIND_QUERY;
                                odata_next = {vnew[2], vnew[1], vnew[0]};
                            end
                        end
                        MODE_HIT:
                        begin
                            okind_next = KIND_HIT;
                            odata_next = {vcur[2], vcur[1], vcur[0]};
                        end
                        default:
                        begin
                            okind_next = KIND_NORAY;
                            odata_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_WALK;
            walking_reg <= 1'b0;
            ovld_reg    <= 1'b0;
            tmin_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            walking_reg <= walking_next;
            ovld_reg    <= ovld_next;
            tmin_reg    <= tmin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        okind_reg <= okind_next;
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = odata_reg;

endmodule

[hdl/vrt_div.sv]
// ---------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// ---------------------------------------------------------------------------
module vrt_div
    import vrt_pkg::*;
#(
    parameter int NW = 33
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [17:0]   den,
    output logic          busy,
    output vrt_time_t     quot
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [NW-1:0] q_reg, q_next;
    logic [17:0]   rem_reg, rem_next;
    logic [17:0]   den_reg, den_next;
    logic [18:0]   rem_sh;
    logic          ge;
    logic [NW+31:0] q_ext;

    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[NW-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 18'(rem_sh - {1'b0, den_reg}) : rem_sh[17:0];
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign q_ext = {32'b0, q_reg};
    assign busy  = busy_reg;
    assign quot  = (den_reg == '0 || |q_ext[NW+31:32]) ? TIME_SAT : q_reg[31:0];

endmodule

[hdl/vrt_lane.sv]
// ---------------------------------------------------------------------------
// vrt_lane
// One axis: ray latch, step and first-crossing dividers, voxel datapath.
// ---------------------------------------------------------------------------
module vrt_lane
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int EPS_LSB   = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  vrt_lane_ctl_t      ctl,
    input  logic signed [31:0] origin,
    input  logic signed [17:0] dir,
    input  vrt_time_t          tmin,
    output logic               busy,
    output vrt_time_t          crossing,
    output logic [15:0]        voxel_new,
    output logic [15:0]        voxel_cur
);

    localparam int NW  = 2 * FRAC_BITS + 1;
    localparam int W1  = (32 + FRAC_BITS > 52) ? 32 + FRAC_BITS : 52;
    localparam int W2  = (W1 > 2 * FRAC_BITS + 16) ? W1 : 2 * FRAC_BITS + 16;
    localparam int AW  = W2 + 1;

    logic signed [31:0] org_reg;
    logic signed [17:0] dir_reg;
    vrt_time_t          step_reg, cross_reg;
    logic [15:0]        vox_reg;
    logic signed [51:0] prod_reg, prod_next;
    logic               busy_d_reg;

    logic [17:0]          ad;
    logic [FRAC_BITS-1:0] frac;
    logic [FRAC_BITS:0]   mag;
    logic                 busy_s, busy_c;
    vrt_time_t            q_s, q_c;
    logic [32:0]          te;
    logic [32:0]          cross_sum;
    logic signed [AW-1:0] acc;

    assign ad   = dir[17] ? 18'(-dir) : dir;
    assign frac = origin[FRAC_BITS-1:0];
    // distance to the next boundary in the ray direction
    assign mag  = (!dir[17] && dir != '0 && frac != '0)
                  ? ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac})
                  : {1'b0, frac};

    vrt_div #(.NW(NW)) u_div_step (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.load),
        .num   (NW'(1) << (2 * FRAC_BITS)),
        .den   (ad),
        .busy  (busy_s),
        .quot  (q_s)
    );

    vrt_div #(.NW(NW)) u_div_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.load),
        .num   (NW'(mag) << FRAC_BITS),
        .den   (ad),
        .busy  (busy_c),
        .quot  (q_c)
    );

    assign busy = busy_s | busy_c;

    assign te        = {1'b0, tmin} + 33'(EPS_LSB);
    assign prod_next = $signed({1'b0, te}) * dir_reg;
    assign acc       = (AW'(org_reg) <<< FRAC_BITS) + AW'(prod_reg);
    assign voxel_new = acc[2*FRAC_BITS+15:2*FRAC_BITS];
    assign cross_sum = {1'b0, cross_reg} + {1'b0, step_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg    <= '0;
            dir_reg    <= '0;
            step_reg   <= '0;
            cross_reg  <= '0;
            vox_reg    <= '0;
            busy_d_reg <= 1'b0;
        end
        else
        begin
            busy_d_reg <= busy_s | busy_c;
            if (ctl.load)
            begin
                org_reg <= origin;
                dir_reg <= dir;
            end
            // quotients are final in the first cycle after the dividers go idle
            if (busy_d_reg && !(busy_s || busy_c))
            begin
                step_reg  <= q_s;
                cross_reg <= q_c;
            end
            if (ctl.upd)
            begin
                vox_reg <= voxel_new;
                if (cross_reg == tmin)
                    cross_reg <= cross_sum[32] ? TIME_SAT : cross_sum[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
            prod_reg <= prod_next;
    end

    assign crossing  = cross_reg;
    assign voxel_cur = vox_reg;

endmodule

[hdl/vrt_merge.sv]
// ---------------------------------------------------------------------------
// vrt_merge
// Least crossing time over the three lanes.
// ---------------------------------------------------------------------------
module vrt_merge
    import vrt_pkg::*;
(
    input  vrt_time_t cross_x,
    input  vrt_time_t cross_y,
    input  vrt_time_t cross_z,
    output vrt_time_t tmin
);

    vrt_time_t m_xy;

    assign m_xy = (cross_y < cross_x) ? cross_y : cross_x;
    assign tmin = (cross_z < m_xy) ? cross_z : m_xy;

endmodule

[hdl/vrt_checker.sv]
// ---------------------------------------------------------------------------
// vrt_checker
// Port-level checks of the traversal engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "voxel_ray_traversal_defines.svh"

module vrt_checker
    import vrt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    `VRT_ASSERT(a_miss_voxel, m_tvalid && m_tuser == KIND_MISS, m_tdata == {16'h0000, 16'hFFFF, 16'h0000}, "miss must carry voxel (0,-1,0)")
    `VRT_ASSERT(a_noray_voxel, m_tvalid && m_tuser == KIND_NORAY, m_tdata == 48'h0, "answer without ray must carry zero voxel")
    `VRT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while a transaction is in work")
    `VRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);
